>>> design/normalized_nearest_case_search_macros.svh
// assertion macros for the nearest case search block
// depends on nothing; included by the top level
`ifndef NORMALIZED_NEAREST_CASE_SEARCH_MACROS_SVH
`define NORMALIZED_NEAREST_CASE_SEARCH_MACROS_SVH
// a property that must hold at every edge out of reset
`define NNCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// an implication whose consequence is checked in the cycle after its condition
`define NNCS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

>>> design/nncs_pkg.sv
// shared types and constants of the nearest case search block
// depends on nothing
package nncs_pkg;
  localparam int MaxCasesDefault  = 1024;
  localparam int CoordDimsDefault = 8;
  localparam int CoordBitsDefault = 24;
  localparam int DistBits = 40;
  localparam int InvBits  = 32;
  localparam int IdxBits  = 10;
  localparam logic [DistBits-1:0] DistMax = '1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_FULL   = 2'd1,
    ST_ANSWER = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // request to the shared divide / square-root unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [79:0] num;
    logic [63:0] den;
  } du_req_t;

  typedef struct packed {
    logic        done;
    logic [79:0] quo;
    logic [63:0] rem;
  } du_rsp_t;
endpackage

>>> design/nncs_divsqrt.sv
// shared iterative divider and square-root unit, one bit per cycle
// depends on nncs_pkg
module nncs_divsqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  nncs_pkg::du_req_t req,
  output nncs_pkg::du_rsp_t rsp
);
  import nncs_pkg::*;

  logic        busy_r, busy_nxt;
  logic        sq_r, sq_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [79:0] n_r, n_nxt;
  logic [63:0] d_r, d_nxt;
  logic [80:0] rm_r, rm_nxt;
  logic [79:0] q_r, q_nxt;
  logic        done_r, done_nxt;
  logic [80:0] sh;
  logic [80:0] trial;

  // restoring step: divide shifts one bit, sqrt shifts two
  always_comb begin
    busy_nxt = busy_r;
    sq_nxt   = sq_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    d_nxt    = d_r;
    rm_nxt   = rm_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    sh       = '0;
    trial    = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      sq_nxt   = req.is_sqrt;
      n_nxt    = req.num;
      d_nxt    = req.den;
      rm_nxt   = '0;
      q_nxt    = '0;
      cnt_nxt  = req.is_sqrt ? 7'd32 : 7'd80;
    end else if (busy_r) begin
      if (sq_r) begin
        sh    = {rm_r[78:0], n_r[63:62]};
        trial = {q_r[78:0], 2'b01};
        n_nxt = {n_r[77:0], 2'b00};
      end else begin
        sh    = {rm_r[79:0], n_r[79]};
        trial = {17'd0, d_r};
        n_nxt = {n_r[78:0], 1'b0};
      end
      if (sh >= trial) begin
        rm_nxt = sh - trial;
        q_nxt  = {q_r[78:0], 1'b1};
      end else begin
        rm_nxt = sh;
        q_nxt  = {q_r[78:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      sq_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      sq_r   <= sq_nxt;
    end
    n_r  <= n_nxt;
    d_r  <= d_nxt;
    rm_r <= rm_nxt;
    q_r  <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
  assign rsp.rem  = rm_r[63:0];
endmodule

>>> design/nncs_mac.sv
// shared squaring multiply-accumulate unit with saturation
// depends on nncs_pkg
module nncs_mac (
  input  logic        clk,
  input  logic        en,
  input  logic        clr,
  input  logic        sq_mode,
  input  logic [63:0] mag,
  input  logic [31:0] inv,
  input  logic [2:0]  sat_lim,
  output logic [63:0] acc
);
  import nncs_pkg::*;

  // stage one: product, stage two: scale and accumulate
  logic [63:0] p_r;
  logic        ovf_r;
  logic        vld_r;
  logic        md_r;
  logic [63:0] z;
  logic [63:0] zz;
  logic [63:0] term;
  logic [64:0] sum;
  logic        zovf;

  always_ff @(posedge clk) begin
    vld_r <= en;
    md_r  <= sq_mode;
    if (sq_mode) begin
      ovf_r <= (mag[63:32] != '0);
      p_r   <= mag[31:0] * mag[31:0];
    end else begin
      ovf_r <= (mag[63:40] != '0);
      p_r   <= {24'd0, mag[39:0]} * {32'd0, inv};
    end
  end

  // distance path rescales the product to z, then squares z in the same stage
  always_comb begin
    z    = p_r >> 12;
    zovf = (z[63:32] != '0);
    zz   = z[31:0] * z[31:0];
    term = md_r ? p_r : (zz >> 20);
    sum  = {1'b0, acc} + {1'b0, term};
  end

  logic [63:0] acc_r;
  always_ff @(posedge clk) begin
    if (clr) begin
      acc_r <= '0;
    end else if (vld_r) begin
      if (md_r) begin
        acc_r <= (ovf_r || sum[64]) ? '1 : sum[63:0];
      end else begin
        acc_r <= (ovf_r || zovf || sum >= {25'd0, DistMax} || acc >= {24'd0, DistMax}) ?
                 {24'd0, DistMax} : sum[63:0];
      end
    end
  end
  assign acc = acc_r;
  logic unused_lim;
  assign unused_lim = ^sat_lim;
endmodule

>>> design/normalized_nearest_case_search.sv
// top level of the nearest case search: store, statistics and query sequencer
// depends on nncs_pkg, nncs_mac, nncs_divsqrt, macros header
//
// channel  dir  tdata / tuser
// in_      in   tdata: opcode, 8 coords | tuser none
// out_     out  tdata: status, nearest_index, nearest_distance_sq
//
// a load answers after one store write per coordinate;
// clears, reserved ops, dropped loads and empty queries answer the next cycle.
// a query reads, accumulates and rescales each coordinate of each case and
// compares once per case; after a load it first refreshes the statistics
// through the shared divider.
// reset is synchronous active low; store contents are not cleared;
// the input is not ready while an item is in work or its result waits.
module normalized_nearest_case_search #(
  parameter int MAX_CASES  = nncs_pkg::MaxCasesDefault,
  parameter int COORD_BITS = nncs_pkg::CoordBitsDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // opcode[1:0], wavelength, radius, a1_x, a1_y, a1_z, a2_x, a2_y, a2_z
  input  logic [((2+8*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status[1:0], nearest_index[11:2], nearest_distance_sq[51:12]
  output logic [55:0] out_tdata
);
  import nncs_pkg::*;
  `include "normalized_nearest_case_search_macros.svh"

  localparam int Dims   = 8;
  localparam int CntW   = $clog2(MAX_CASES + 1);
  localparam int AddrW  = (MAX_CASES > 1) ? $clog2(MAX_CASES) : 1;
  localparam int MemW   = AddrW + 3;
  localparam int SumW   = COORD_BITS + CntW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MEAN, S_MEANW, S_VAR, S_VARW, S_VDIV, S_VDIVW,
    S_SQRT, S_SQRTW, S_INV, S_INVW, S_DIST, S_DISTW, S_CMP, S_OUT
  } state_t;

  state_t state_r;
  logic [CntW-1:0] count_r;
  logic            fresh_r;
  logic signed [SumW-1:0] sum_r [Dims];
  logic signed [COORD_BITS-1:0] mean_r [Dims];
  logic [InvBits-1:0] inv_r [Dims];
  logic [1:0]  op_r;
  logic signed [COORD_BITS-1:0] tgt_r [Dims];
  logic [2:0]  dim_r;
  logic [CntW-1:0] idx_r;
  logic [CntW:0] pipe_r;
  logic [63:0] acc_save_r;
  logic [DistBits-1:0] best_r;
  logic [CntW-1:0] best_idx_r;
  logic [1:0]  status_r;
  logic [IdxBits-1:0] oidx_r;
  logic [DistBits-1:0] odist_r;

  // coordinate memory, one read port
  logic signed [COORD_BITS-1:0] mem [2**MemW];
  logic signed [COORD_BITS-1:0] rd_r;
  logic [MemW-1:0] raddr;
  logic            wen;
  logic [MemW-1:0] waddr;
  logic signed [COORD_BITS-1:0] wdat;
  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdat;
    rd_r <= mem[raddr];
  end

  // shared units
  du_req_t dreq;
  du_rsp_t drsp;
  nncs_divsqrt u_du (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic        mac_en, mac_clr, mac_sq;
  logic [63:0] mac_mag, mac_acc;
  logic signed [COORD_BITS:0] diff;
  nncs_mac u_mac (.clk(clk), .en(mac_en), .clr(mac_clr), .sq_mode(mac_sq),
    .mag(mac_mag), .inv(inv_r[dim_r]), .sat_lim(dim_r), .acc(mac_acc));

  assign diff    = (state_r == S_VARW) ? rd_r - mean_r[dim_r] : rd_r - tgt_r[dim_r];
  assign mac_mag = {{(63-COORD_BITS){1'b0}},
                    diff[COORD_BITS] ? COORD_BITS'(0) - diff : diff};

  // read one address ahead of the element the mac takes
  logic [CntW-1:0] idx_nx;
  assign idx_nx = idx_r + CntW'(1);

  logic stream;
  assign stream = (state_r == S_VAR || state_r == S_DIST) &&
                  pipe_r[CntW:1] != '0 && pipe_r[0];
  assign raddr = (state_r == S_VARW)  ? {idx_nx[AddrW-1:0], dim_r} :
                 (state_r == S_DISTW) ? {idx_r[AddrW-1:0], dim_r + 3'd1} :
                                        {idx_r[AddrW-1:0], dim_r};
  assign waddr = {count_r[AddrW-1:0], dim_r};
  assign wdat  = tgt_r[dim_r];
  assign wen   = (state_r == S_LOAD);

  logic [63:0] var_r;
  logic [63:0] sum_ext;
  assign sum_ext = 64'(sum_r[dim_r]);

  assign in_tready = (state_r == S_IDLE) && !out_tvalid;
  logic out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, odist_r, oidx_r, status_r};

  always_comb begin
    dreq = '0;
    unique case (state_r)
      S_MEAN: begin
        dreq.start = 1'b1;
        dreq.num   = sum_r[dim_r] < 0 ? 80'(-sum_r[dim_r]) : 80'(sum_r[dim_r]);
        dreq.den   = 64'(count_r);
      end
      S_VDIV: begin
        dreq.start = 1'b1;
        dreq.num   = {mac_acc, 16'd0};
        dreq.den   = 64'(count_r);
      end
      S_SQRT: begin
        dreq.start   = 1'b1;
        dreq.is_sqrt = 1'b1;
        dreq.num     = {16'd0, var_r};
      end
      S_INV: begin
        dreq.start = 1'b1;
        dreq.num   = 80'd1 << 40;
        dreq.den   = drsp.quo[63:0];
      end
      default: ;
    endcase
  end

  // step the mac for each streamed read; one element per cycle in the variance pass
  always_comb begin
    mac_en  = (state_r == S_VARW || state_r == S_DISTW) && pipe_r[0];
    mac_sq  = (state_r == S_VARW);
    mac_clr = (state_r == S_VAR || state_r == S_DIST);
  end

  logic [CntW-1:0] cnt_m1;
  assign cnt_m1 = count_r - CntW'(1);
  logic neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      fresh_r <= 1'b0;
      out_v_r <= 1'b0;
      for (int j = 0; j < Dims; j++) begin
        sum_r[j]  <= '0;
        mean_r[j] <= '0;
        inv_r[j]  <= '0;
      end
    end else begin
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          op_r <= in_tdata[1:0];
          for (int j = 0; j < Dims; j++)
            tgt_r[j] <= in_tdata[2+j*COORD_BITS +: COORD_BITS];
          dim_r    <= '0;
          oidx_r   <= '0;
          odist_r  <= '0;
          unique case (in_tdata[1:0])
            OP_LOAD: begin
              if (count_r >= CntW'(MAX_CASES)) begin
                status_r <= ST_FULL;
                out_v_r  <= 1'b1;
              end else begin
                status_r <= ST_STORED;
                state_r  <= S_LOAD;
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                status_r <= ST_EMPTY;
                out_v_r  <= 1'b1;
              end else begin
                status_r <= ST_STORED;
                state_r  <= fresh_r ? S_DIST : S_MEAN;
              end
              idx_r <= '0;
            end
            OP_CLEAR: begin
              status_r <= ST_STORED;
              count_r  <= '0;
              fresh_r  <= 1'b0;
              for (int j = 0; j < Dims; j++) begin
                sum_r[j] <= '0; mean_r[j] <= '0; inv_r[j] <= '0;
              end
              out_v_r <= 1'b1;
            end
            default: begin
              status_r <= ST_STORED;
              out_v_r  <= 1'b1;
            end
          endcase
        end
        S_LOAD: begin
          sum_r[dim_r] <= sum_r[dim_r] + SumW'(tgt_r[dim_r]);
          dim_r <= dim_r + 3'd1;
          if (dim_r == 3'd7) begin
            count_r <= count_r + CntW'(1);
            fresh_r <= 1'b0;
            out_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_MEAN: begin
          neg_r   <= sum_r[dim_r] < 0;
          state_r <= S_MEANW;
        end
        S_MEANW: if (drsp.done) begin
          // floor division: negative sums round away from zero on remainder
          mean_r[dim_r] <= neg_r ?
            COORD_BITS'(-(SumW'(drsp.quo) + SumW'(drsp.rem != '0))) :
            COORD_BITS'(drsp.quo);
          idx_r   <= '0;
          pipe_r  <= {count_r, 1'b0};
          state_r <= S_VAR;
        end
        S_VAR, S_DIST: begin
          // issue address, data arrives next cycle
          pipe_r  <= {count_r, 1'b1};
          state_r <= (state_r == S_VAR) ? S_VARW : S_DISTW;
        end
        S_VARW: begin
          // one case per cycle; the accumulator settles in the divide state
          if (pipe_r[0]) begin
            if (idx_r == cnt_m1) pipe_r <= '0;
            else idx_r <= idx_nx;
          end else begin
            state_r <= S_VDIV;
          end
        end
        S_DISTW: begin
          // a mac step, then a dim_r step, per coordinate so the next read can follow dim_r
          if (pipe_r[0]) begin
            pipe_r <= '0;
          end else if (dim_r == 3'd7) begin
            dim_r   <= '0;
            state_r <= S_CMP;
          end else begin
            dim_r  <= dim_r + 3'd1;
            pipe_r <= {count_r, 1'b1};
          end
        end
        S_CMP: begin
          // the last term has landed; keep the first of equal distances
          if (idx_r == '0 || mac_acc[DistBits-1:0] < best_r) begin
            best_r     <= mac_acc[DistBits-1:0];
            best_idx_r <= idx_r;
          end
          if (idx_r == cnt_m1) begin
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_nx;
            state_r <= S_DIST;
          end
        end
        S_VDIV: state_r <= S_VDIVW;
        S_VDIVW: if (drsp.done) begin
          var_r   <= (drsp.quo[79:64] != '0) ? '1 : drsp.quo[63:0];
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (var_r == '0) begin
            inv_r[dim_r] <= '0;
            state_r      <= S_INVW;
          end else state_r <= S_SQRTW;
        end
        S_SQRTW: if (drsp.done) state_r <= S_INV;
        S_INV: state_r <= S_INVW;
        S_INVW: if (var_r == '0 || drsp.done) begin
          if (var_r != '0)
            inv_r[dim_r] <= (drsp.quo[79:32] != '0) ? '1 : drsp.quo[31:0];
          dim_r <= dim_r + 3'd1;
          if (dim_r == 3'd7) begin
            fresh_r <= 1'b1;
            idx_r   <= '0;
            state_r <= S_DIST;
          end else state_r <= S_MEAN;
        end
        S_OUT: begin
          status_r <= ST_ANSWER;
          oidx_r   <= IdxBits'(best_idx_r);
          odist_r  <= best_r;
          out_v_r  <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{stream, sum_ext, acc_save_r, op_r};
  always_ff @(posedge clk) acc_save_r <= mac_acc;

  `NNCS_ASSERT(a_busy_not_ready, !(state_r != S_IDLE && in_tready), "ready while busy")
  `NNCS_ASSERT(a_count_cap, count_r <= CntW'(MAX_CASES), "case count over capacity")
  `NNCS_ASSERT_NEXT(a_out_after_query, state_r == S_OUT, out_tvalid && status_r == ST_ANSWER,
    "query result missing")
endmodule
